// ===== src/bba_pkg.sv =====
package bba_pkg;

  localparam int MAX_BLOCKS    = 4096;
  localparam int MAP_WORD_BITS = 32;
  localparam int MAP_WORDS     = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int BLK_W         = 12;
  localparam int TOTAL_W       = 13;
  localparam int WORD_AW       = $clog2(MAP_WORDS);
  localparam int BIT_W         = $clog2(MAP_WORD_BITS);
  localparam int GRP_SIZE      = 16;
  localparam int GRPS          = MAP_WORDS / GRP_SIZE;
  localparam int GRP_W         = $clog2(GRPS);
  localparam int GIDX_W        = $clog2(GRP_SIZE);

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(MAX_BLOCKS);

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_QUERY   = 2'd2;
  localparam logic [1:0] REQ_RESERVE = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_BADBLK  = 2'd2;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [BLK_W-1:0] block_number;
  } bba_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [BLK_W-1:0] result_block;
    logic             block_free;
  } bba_out_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic pick;
    logic rd;
    logic ex;
  } bba_cmd_t;

endpackage

// ===== src/bba_ctrl.sv =====
module bba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              req_alloc,
  output logic              busy,
  output bba_pkg::bba_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_PICK = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_EX   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = req_alloc ? ST_SCAN : ST_RD;
        end
      end
      ST_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EX;
      end
      ST_EX: begin
        cmd.ex    = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

`ifndef SYNTH
  a_ex_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EX |=> state_r == ST_IDLE)
    else $error("execute step not followed by idle");
  a_alloc_scans: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && req_alloc |=> state_r == ST_SCAN)
    else $error("allocate request skipped the scan");
  a_rd_before_ex: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EX |-> $past(state_r) == ST_RD)
    else $error("execute step without a map read");
`endif

endmodule

// ===== src/bba_dp.sv =====
module bba_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bba_pkg::bba_cmd_t             cmd,
  input  bba_pkg::bba_in_t              in_data,
  input  logic                          cfg_we,
  input  logic [bba_pkg::TOTAL_W-1:0]   cfg_wdata,
  output logic                          out_valid,
  output bba_pkg::bba_out_t             out_data
);

  localparam int WB = bba_pkg::MAP_WORD_BITS;

  logic [bba_pkg::TOTAL_W-1:0]       total_r;
  bba_pkg::bba_in_t                  req_r;
  logic [bba_pkg::WORD_AW-1:0]       addr_r;
  logic                              none_r;
  logic [WB-1:0]                     mem_r [bba_pkg::MAP_WORDS];
  logic [bba_pkg::MAP_WORDS-1:0]     row_ok_r;
  logic [bba_pkg::MAP_WORDS-1:0]     nz_r;
  logic [WB-1:0]                     rd_word_r;
  logic                              rd_ok_r;
  logic [bba_pkg::GRPS-1:0]          gany_r;
  logic [bba_pkg::GIDX_W-1:0]        gidx_r [bba_pkg::GRPS];
  logic                              out_valid_r;
  bba_pkg::bba_out_t                 out_r;

  logic [bba_pkg::TOTAL_W-1:0]       lim;
  logic [WB-1:0]                     word;
  logic [WB-1:0]                     masked;
  logic [WB-1:0]                     bit_mask;
  logic [WB-1:0]                     wr_word;
  logic                              wr_en;
  logic [bba_pkg::BIT_W-1:0]         low_bit;
  logic [bba_pkg::BLK_W-1:0]         cand;
  logic                              blk_free;
  logic                              blk_in;
  logic [bba_pkg::GRP_W-1:0]         pick_grp;
  logic                              pick_any;
  bba_pkg::bba_out_t                 res;

  function automatic logic [bba_pkg::GIDX_W-1:0] lowest16(
    input logic [bba_pkg::GRP_SIZE-1:0] v
  );
    logic [bba_pkg::GIDX_W-1:0] idx;
    idx = '0;
    for (int k = bba_pkg::GRP_SIZE - 1; k >= 0; k--) begin
      if (v[k]) idx = bba_pkg::GIDX_W'(k);
    end
    return idx;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= bba_pkg::TOTAL_RESET;
    end else if (cfg_we) begin
      total_r <= cfg_wdata;
    end
  end

  assign lim = (total_r > bba_pkg::TOTAL_RESET) ? bba_pkg::TOTAL_RESET : total_r;

  // Group stage of the summary search
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      for (int g = 0; g < bba_pkg::GRPS; g++) begin
        gany_r[g] <= |nz_r[g*bba_pkg::GRP_SIZE +: bba_pkg::GRP_SIZE];
        gidx_r[g] <= lowest16(nz_r[g*bba_pkg::GRP_SIZE +: bba_pkg::GRP_SIZE]);
      end
    end
  end

  always_comb begin
    pick_grp = '0;
    pick_any = 1'b0;
    for (int g = bba_pkg::GRPS - 1; g >= 0; g--) begin
      if (gany_r[g]) begin
        pick_grp = bba_pkg::GRP_W'(g);
        pick_any = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_data;
      addr_r <= in_data.block_number[bba_pkg::BLK_W-1 -: bba_pkg::WORD_AW];
      none_r <= 1'b0;
    end else if (cmd.pick) begin
      addr_r <= {pick_grp, gidx_r[pick_grp]};
      none_r <= !pick_any;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_word_r <= mem_r[addr_r];
    end
    if (wr_en) begin
      mem_r[addr_r] <= wr_word;
    end
  end

  // Unwritten rows read as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ok_r <= '0;
      nz_r     <= '1;
      rd_ok_r  <= 1'b0;
    end else begin
      if (cmd.rd) rd_ok_r <= row_ok_r[addr_r];
      if (wr_en) begin
        row_ok_r[addr_r] <= 1'b1;
        nz_r[addr_r]     <= |(wr_word & ((addr_r == '0) ? ~WB'(1) : '1));
      end
    end
  end

  assign word   = rd_ok_r ? rd_word_r : '1;
  assign masked = word & ((addr_r == '0) ? ~WB'(1) : '1);

  always_comb begin
    low_bit = '0;
    for (int k = WB - 1; k >= 0; k--) begin
      if (masked[k]) low_bit = bba_pkg::BIT_W'(k);
    end
  end

  assign cand     = {addr_r, low_bit};
  assign bit_mask = WB'(1) << req_r.block_number[bba_pkg::BIT_W-1:0];
  assign blk_in   = ({1'b0, req_r.block_number} < lim);
  assign blk_free = (req_r.block_number != '0) && blk_in && |(word & bit_mask);

  always_comb begin
    res              = '0;
    res.status       = bba_pkg::STAT_OK;
    res.result_block = req_r.block_number;
    wr_en            = 1'b0;
    wr_word          = word;
    case (req_r.req_type)
      bba_pkg::REQ_ALLOC: begin
        res.result_block = '0;
        if (!none_r && (|masked) && ({1'b0, cand} < lim)) begin
          res.result_block = cand;
          wr_word          = word & ~(WB'(1) << low_bit);
          wr_en            = cmd.ex;
        end else begin
          res.status = bba_pkg::STAT_NOSPACE;
        end
      end
      bba_pkg::REQ_FREE: begin
        if (req_r.block_number <= bba_pkg::BLK_W'(1) || !blk_in) begin
          res.status = bba_pkg::STAT_BADBLK;
        end else begin
          res.block_free = 1'b1;
          wr_word        = word | bit_mask;
          wr_en          = cmd.ex;
        end
      end
      bba_pkg::REQ_QUERY: begin
        res.block_free = blk_free;
      end
      bba_pkg::REQ_RESERVE: begin
        if (blk_free) begin
          wr_word = word & ~bit_mask;
          wr_en   = cmd.ex;
        end else begin
          res.status = bba_pkg::STAT_NOSPACE;
        end
      end
      default: res.status = bba_pkg::STAT_NOSPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.ex;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ex) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for more than one cycle");
  a_alloc_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ex && req_r.req_type == bba_pkg::REQ_ALLOC && res.status == bba_pkg::STAT_OK
    |-> res.result_block != '0 && {1'b0, res.result_block} < lim)
    else $error("allocated block zero or beyond the count");
  a_summary_agrees: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ex && req_r.req_type == bba_pkg::REQ_ALLOC && !none_r |-> |masked)
    else $error("summary marks a word free that holds no free block");
  a_write_only_on_ex: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> cmd.ex && res.status == bba_pkg::STAT_OK)
    else $error("map written outside a successful request");
`endif

endmodule

// ===== src/block_bitmap_allocator_top.sv =====
// Channel   Ports                       Handshake
// request   start, busy, in_data        taken when start is high and busy is low
// result    out_valid, out_data         one-cycle strobe, no back-pressure
// config    cfg_we, cfg_wdata           written when cfg_we is high
//
// Allocate runs a registered search over the per-word free summary (scan,
// then pick), a map read, an update and the output register. Free, query
// and reserve skip the search: map read, update, output register.
// busy is high while a request runs; it falls as the result is strobed.
// Reset is synchronous; the map reads as all free without a clearing pass.
module block_bitmap_allocator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  bba_pkg::bba_in_t              in_data,
  input  logic                          cfg_we,
  input  logic [bba_pkg::TOTAL_W-1:0]   cfg_wdata,
  output logic                          out_valid,
  output bba_pkg::bba_out_t             out_data
);

  bba_pkg::bba_cmd_t cmd;
  logic              req_alloc;

  assign req_alloc = (in_data.req_type == bba_pkg::REQ_ALLOC);

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req_alloc (req_alloc),
    .busy      (busy),
    .cmd       (cmd)
  );

  bba_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
